### design/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg - shared types and constants for the articulation point finder
// Request and result payloads, controller command and status groups, and
// the configuration register map.
// ----------------------------------------------------------------------------
package apf_pkg;

  // Default size of the adjacency store (rows and columns).
  localparam int MAX_VERTICES = 32;

  // Fixed field widths of the request and result payloads.
  localparam int VERTEX_W = 5;
  localparam int VCOUNT_W = 6;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Word index of each configuration register (paddr[2]).
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    vertex_t edge_from;
    vertex_t edge_to;
    logic    edge_valid;
    logic    last_edge;
  } edge_req_t;

  typedef struct packed {
    vertex_t vertex_index;
    logic    is_cut_vertex;
    logic    last_result;
  } vtx_result_t;

  // Controller to datapath.
  typedef struct packed {
    logic addr_zero;  // rewind the row address
    logic clr_row;    // zero the addressed row, advance address
    logic set_fwd;    // set bit [from][to] from the request, latch the edge
    logic set_rev;    // set bit [to][from] from the latched edge
    logic load_n;     // capture effective vertex count, rewind vertex under test
    logic vtx_init;   // seed reached set for the vertex under test
    logic pass_init;  // start another sweep over the rows
    logic rd_issue;   // read the addressed row, advance address
    logic emit;       // register a result, advance vertex under test
  } apf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic edge_ok;     // request carries an in-range edge
    logic req_last;    // request closes the graph
    logic clear_last;  // clearing the final row
    logic sweep_last;  // reading the final row of this pass
    logic changed;     // reached set grew during this pass
    logic vtx_last;    // vertex under test is the highest one
    logic n_zero;      // effective vertex count is zero
  } apf_status_t;

endpackage

### design/apf_controller.sv
// ----------------------------------------------------------------------------
// apf_controller - sequencing state machine
// Steps through edge loading, the per-vertex reachability sweeps, result
// emission and the clearing pass over the adjacency store.
// ----------------------------------------------------------------------------
module apf_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  apf_pkg::apf_status_t status,
  output apf_pkg::apf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MIRROR,
    S_START,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state, state_next;
  logic   pend_last, pend_last_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    pend_last_next = pend_last;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_row = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (status.edge_ok) begin
            cmd.set_fwd    = 1'b1;
            pend_last_next = status.req_last;
            state_next     = S_MIRROR;
          end else if (status.req_last) begin
            cmd.load_n = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_MIRROR: begin
        cmd.set_rev = 1'b1;
        if (pend_last) begin
          cmd.load_n = 1'b1;
          state_next = S_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_START: begin
        if (status.n_zero) begin
          cmd.addr_zero = 1'b1;
          state_next    = S_CLEAR;
        end else begin
          cmd.vtx_init = 1'b1;
          state_next   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.rd_issue = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.changed) begin
          cmd.pass_init = 1'b1;
          state_next    = S_SWEEP;
        end else begin
          cmd.emit = 1'b1;
          if (status.vtx_last) begin
            cmd.addr_zero = 1'b1;
            state_next    = S_CLEAR;
          end else begin
            state_next = S_START;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pend_last <= 1'b0;
      busy      <= 1'b1;
    end else begin
      state     <= state_next;
      pend_last <= pend_last_next;
      busy      <= (state_next != S_IDLE);
    end
  end

endmodule

### design/apf_datapath.sv
// ----------------------------------------------------------------------------
// apf_datapath - adjacency memory, reached set and counters
// Holds the bit-matrix adjacency store, grows the reached set one row per
// cycle and forms each result.
// ----------------------------------------------------------------------------
module apf_datapath #(
  parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  apf_pkg::apf_cmd_t             cmd,
  output apf_pkg::apf_status_t          status,
  input  apf_pkg::edge_req_t            request,
  input  logic [apf_pkg::VCOUNT_W-1:0]  vertex_count,
  output apf_pkg::vtx_result_t          result,
  output logic                          strobe
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];

  logic [CNT_W-1:0]        addr;
  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W-1:0]        n_load;
  logic [CNT_W-1:0]        tv;
  logic [IDX_W-1:0]        e_from;
  logic [IDX_W-1:0]        e_to;
  logic [IDX_W-1:0]        rd_idx;
  logic [IDX_W-1:0]        from_i;
  logic [IDX_W-1:0]        to_i;
  logic [IDX_W-1:0]        addr_i;
  logic [MAX_VERTICES-1:0] rd_data;
  logic [MAX_VERTICES-1:0] reached;
  logic [MAX_VERTICES-1:0] rest;
  logic [MAX_VERTICES-1:0] start_vec;
  logic [MAX_VERTICES-1:0] grow;
  logic [31:0]             from_w;
  logic [31:0]             to_w;
  logic [31:0]             vc_w;
  logic                    rd_vld;
  logic                    changed;
  logic                    hit;

  always_comb begin
    from_w = 32'(request.edge_from);
    to_w   = 32'(request.edge_to);
    vc_w   = 32'(vertex_count);
    from_i = from_w[IDX_W-1:0];
    to_i   = to_w[IDX_W-1:0];
    addr_i = addr[IDX_W-1:0];
    n_load = (vc_w > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_w);

    // Vertices still in the graph: below the count, minus the one removed.
    for (int i = 0; i < MAX_VERTICES; i++) begin
      rest[i] = (CNT_W'(i) < n_eff) && (CNT_W'(i) != tv);
    end
    // Seed at the lowest remaining vertex: 1 when vertex 0 is removed.
    start_vec = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << (tv == '0);

    hit  = rd_vld && reached[rd_idx];
    grow = rd_data & rest & ~reached;

    status.edge_ok    = request.edge_valid && (from_w < MAX_VERTICES) &&
                        (to_w < MAX_VERTICES);
    status.req_last   = request.last_edge;
    status.clear_last = (addr == CNT_W'(MAX_VERTICES - 1));
    status.sweep_last = (addr == n_eff - CNT_W'(1));
    status.changed    = changed;
    status.vtx_last   = (tv == n_eff - CNT_W'(1));
    status.n_zero     = (n_eff == '0);
  end

  // Adjacency memory: one write port with bit enables, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.clr_row) begin
      adj_mem[addr_i] <= '0;
    end else if (cmd.set_fwd) begin
      adj_mem[from_i][to_i] <= 1'b1;
    end else if (cmd.set_rev) begin
      adj_mem[e_to][e_from] <= 1'b1;
    end
    if (cmd.rd_issue) begin
      rd_data <= adj_mem[addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_issue;
      strobe <= cmd.emit;
      if (cmd.addr_zero || cmd.vtx_init || cmd.pass_init) begin
        addr <= '0;
      end else if (cmd.clr_row || cmd.rd_issue) begin
        addr <= addr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_fwd) begin
      e_from <= from_i;
      e_to   <= to_i;
    end
    if (cmd.rd_issue) begin
      rd_idx <= addr_i;
    end
    if (cmd.load_n) begin
      n_eff <= n_load;
      tv    <= '0;
    end else if (cmd.emit) begin
      tv <= tv + CNT_W'(1);
    end
    if (cmd.vtx_init) begin
      reached <= start_vec & rest;
    end else if (hit) begin
      reached <= reached | grow;
    end
    if (cmd.vtx_init || cmd.pass_init) begin
      changed <= 1'b0;
    end else if (hit && (grow != '0)) begin
      changed <= 1'b1;
    end
    if (cmd.emit) begin
      result.vertex_index  <= apf_pkg::vertex_t'(tv);
      result.is_cut_vertex <= (reached != rest);
      result.last_result   <= status.vtx_last;
    end
  end

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (addr < n_eff))
    else $error("row read beyond vertex count");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (tv < n_eff))
    else $error("result for vertex beyond vertex count");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("results on back-to-back cycles");

endmodule

### design/articulation_point_finder.sv
// ----------------------------------------------------------------------------
// articulation_point_finder - brute-force cut vertex test over a small graph
// Sequencing: an edge request sets the forward, then the mirrored adjacency
//   bit; a marker-only request closes the graph unwritten. Each vertex is
//   then tested by sweeps over the n rows through the single read port of
//   the adjacency memory until the reached set stops growing, n the count.
// Results come one per vertex, on strobe for one cycle; the receiver cannot
//   stall. A clearing pass over all MAX_VERTICES rows follows each graph.
// Reset: synchronous; busy stays high through the clearing pass.
// ----------------------------------------------------------------------------
module articulation_point_finder #(
  parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  apf_pkg::edge_req_t              request,
  // result channel
  output apf_pkg::vtx_result_t            result,
  output logic                            strobe,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [apf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [apf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [apf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  apf_pkg::apf_cmd_t             cmd;
  apf_pkg::apf_status_t          status;
  logic [apf_pkg::VCOUNT_W-1:0]  vertex_count;
  logic                          cfg_wr;

  // Configuration register. Writes land in the access phase; the word index
  // is paddr[2], so byte offsets inside a word fold onto that word.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= apf_pkg::VCOUNT_RESET;
    end else if (cfg_wr && (paddr[2] == apf_pkg::REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[apf_pkg::VCOUNT_W-1:0];
    end
  end

  // Read back: zero for any word past the register list.
  always_comb begin
    if (paddr[2] == apf_pkg::REG_VERTEX_COUNT) begin
      prdata = apf_pkg::APB_DATA_W'(vertex_count);
    end else begin
      prdata = '0;
    end
  end

  // The controller sequences loading, sweeps and clearing; the datapath
  // owns the adjacency memory and the reached set.
  apf_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  apf_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .request      (request),
    .vertex_count (vertex_count),
    .result       (result),
    .strobe       (strobe)
  );

  // Results only appear while a graph is being worked on.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe while idle");

  // No request is taken in the cycle a result is shown.
  a_no_accept_on_result: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(start && !busy))
    else $error("request accepted during result delivery");

endmodule
